/* rtl/ahfs_pkg.sv */
package ahfs_pkg;

  localparam int unsigned NumOutputsDefault = 8;
  localparam int unsigned OutEnableWidth    = 8;
  localparam int unsigned CfgDataWidth      = 32;
  localparam int unsigned CfgIdxWidth       = 3;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_UDF  = 3'd1,
    ST_HIHI = 3'd2,
    ST_LOLO = 3'd3,
    ST_HIGH = 3'd4,
    ST_LOW  = 3'd5,
    ST_SOFT = 3'd6
  } alarm_status_e;

  typedef enum logic [1:0] {
    SEV_NONE    = 2'd0,
    SEV_MINOR   = 2'd1,
    SEV_MAJOR   = 2'd2,
    SEV_INVALID = 2'd3
  } alarm_sev_e;

  typedef enum logic [1:0] {
    SEL_ALL     = 2'd0,
    SEL_NUMBER  = 2'd1,
    SEL_MASK    = 2'd2,
    SEL_INVALID = 2'd3
  } select_mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_HIHI_LIMIT     = 3'd0,
    REG_HIGH_LIMIT     = 3'd1,
    REG_LOW_LIMIT      = 3'd2,
    REG_LOLO_LIMIT     = 3'd3,
    REG_HYSTERESIS     = 3'd4,
    REG_SEVERITIES     = 3'd5,
    REG_SELECT_MODE    = 3'd6,
    REG_VALUE_DEADBAND = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               undefined_flag;
    logic [15:0]        select_number;
  } req_t;

  typedef struct packed {
    logic signed [31:0]        out_value;
    logic [OutEnableWidth-1:0] out_enable;
    logic [2:0]                alarm_status;
    logic [1:0]                alarm_severity;
    logic                      event_flag;
  } rsp_t;

endpackage

/* rtl/alarm_hysteresis_fanout_select_core.sv */
// Four-level threshold alarm with hysteresis and output-enable fan-out.
// Input channel: in_valid_i / in_ready_o carry one request (sample, undefined
// flag, selector number). Output channel: out_valid_o / out_ready_i carry one
// result per request (value, enable mask, alarm status, severity, event).
// A request is held in an input register; grading, fan-out selection and the
// event check run combinationally from there into the result register, which
// loads when it is empty or its result is being taken. Throughput is one
// request per cycle while the receiver keeps taking results; the hysteresis
// state (last alarm level, last posted value, previous status and severity)
// is updated together with the result register. Configuration is written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per cycle; the
// user must write only while no request is in flight; the block does not
// enforce it. Reset clears the configuration registers, the alarm state and
// both valid flags, not the input and result data registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o then drops until the result is taken.
module alarm_hysteresis_fanout_select_core #(
  parameter int unsigned NUM_OUTPUTS = ahfs_pkg::NumOutputsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ahfs_pkg::req_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ahfs_pkg::rsp_t                      out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [ahfs_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [ahfs_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);
  import ahfs_pkg::*;

  localparam int unsigned EnW =
    (NUM_OUTPUTS > OutEnableWidth) ? NUM_OUTPUTS : OutEnableWidth;

  logic signed [31:0] hihi_q, high_q, low_q, lolo_q;
  logic [30:0]        hyst_q, deadband_q;
  logic [9:0]         sevs_q;
  select_mode_e       mode_q;

  logic               in_valid_q;
  req_t               in_q;
  logic               out_valid_q;
  rsp_t               out_q;

  logic signed [31:0] last_level_q, last_level_d;
  logic signed [31:0] last_posted_q, last_posted_d;
  alarm_status_e      prev_status_q;
  logic [1:0]         prev_sev_q;

  logic               advance;
  logic signed [32:0] val_x, h_x, hihi_lo, lolo_hi, high_lo, low_hi;
  logic signed [32:0] delta, delta_abs;
  logic               hit_hihi, hit_lolo, hit_high, hit_low;
  alarm_status_e      status_lvl, status;
  logic [1:0]         sev_lvl, sev;
  logic [EnW-1:0]     en_wide;
  logic               sel_err;
  logic               over_band;
  rsp_t               rsp_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hihi_q     <= '0;
      high_q     <= '0;
      low_q      <= '0;
      lolo_q     <= '0;
      hyst_q     <= '0;
      sevs_q     <= '0;
      mode_q     <= SEL_ALL;
      deadband_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HIHI_LIMIT:     hihi_q     <= cfg_wdata_i;
        REG_HIGH_LIMIT:     high_q     <= cfg_wdata_i;
        REG_LOW_LIMIT:      low_q      <= cfg_wdata_i;
        REG_LOLO_LIMIT:     lolo_q     <= cfg_wdata_i;
        REG_HYSTERESIS:     hyst_q     <= cfg_wdata_i[30:0];
        REG_SEVERITIES:     sevs_q     <= cfg_wdata_i[9:0];
        REG_SELECT_MODE:    mode_q     <= select_mode_e'(cfg_wdata_i[1:0]);
        REG_VALUE_DEADBAND: deadband_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // grade against the limits, priority hihi, lolo, high, low; an undefined sample grades as UDF instead
  always_comb begin
    val_x   = {in_q.sample_value[31], in_q.sample_value};
    h_x     = {2'b00, hyst_q};
    hihi_lo = {hihi_q[31], hihi_q} - h_x;
    lolo_hi = {lolo_q[31], lolo_q} + h_x;
    high_lo = {high_q[31], high_q} - h_x;
    low_hi  = {low_q[31], low_q} + h_x;

    hit_hihi = (sevs_q[1:0] != SEV_NONE) &&
               ((in_q.sample_value >= hihi_q) ||
                ((last_level_q == hihi_q) && (val_x >= hihi_lo)));
    hit_lolo = (sevs_q[3:2] != SEV_NONE) &&
               ((in_q.sample_value <= lolo_q) ||
                ((last_level_q == lolo_q) && (val_x <= lolo_hi)));
    hit_high = (sevs_q[5:4] != SEV_NONE) &&
               ((in_q.sample_value >= high_q) ||
                ((last_level_q == high_q) && (val_x >= high_lo)));
    hit_low  = (sevs_q[7:6] != SEV_NONE) &&
               ((in_q.sample_value <= low_q) ||
                ((last_level_q == low_q) && (val_x <= low_hi)));

    status_lvl   = ST_NONE;
    sev_lvl      = SEV_NONE;
    last_level_d = last_level_q;
    if (in_q.undefined_flag) begin
      if (sevs_q[9:8] != SEV_NONE) begin
        status_lvl = ST_UDF;
        sev_lvl    = sevs_q[9:8];
      end
    end else begin
      priority if (hit_hihi) begin
        status_lvl   = ST_HIHI;
        sev_lvl      = sevs_q[1:0];
        last_level_d = hihi_q;
      end else if (hit_lolo) begin
        status_lvl   = ST_LOLO;
        sev_lvl      = sevs_q[3:2];
        last_level_d = lolo_q;
      end else if (hit_high) begin
        status_lvl   = ST_HIGH;
        sev_lvl      = sevs_q[5:4];
        last_level_d = high_q;
      end else if (hit_low) begin
        status_lvl   = ST_LOW;
        sev_lvl      = sevs_q[7:6];
        last_level_d = low_q;
      end else begin
        last_level_d = in_q.sample_value;
      end
    end
  end

  // output-enable fan-out
  always_comb begin
    en_wide = '0;
    sel_err = 1'b0;
    unique case (mode_q)
      SEL_ALL: begin
        for (int unsigned i = 0; i < EnW; i++) begin
          en_wide[i] = (i < NUM_OUTPUTS);
        end
      end
      SEL_NUMBER: begin
        sel_err = (in_q.select_number > 16'(NUM_OUTPUTS));
        for (int unsigned i = 0; i < EnW; i++) begin
          en_wide[i] = (i < NUM_OUTPUTS) && (in_q.select_number == 16'(i + 1));
        end
      end
      SEL_MASK: begin
        for (int unsigned i = 0; i < EnW; i++) begin
          en_wide[i] = (i < NUM_OUTPUTS) && in_q.select_number[i];
        end
      end
      default: sel_err = 1'b1;
    endcase
  end

  always_comb begin
    status = status_lvl;
    sev    = sev_lvl;
    if (sel_err && (sev_lvl != SEV_INVALID)) begin
      status = ST_SOFT;
      sev    = SEV_INVALID;
    end

    delta     = {last_posted_q[31], last_posted_q} - val_x;
    delta_abs = delta[32] ? -delta : delta;
    over_band = (delta_abs > {2'b00, deadband_q});

    last_posted_d = over_band ? in_q.sample_value : last_posted_q;

    rsp_d.out_value      = in_q.sample_value;
    rsp_d.out_enable     = en_wide[OutEnableWidth-1:0];
    rsp_d.alarm_status   = status;
    rsp_d.alarm_severity = sev;
    rsp_d.event_flag     = (status != prev_status_q) || (sev != prev_sev_q) || over_band;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      last_level_q  <= '0;
      last_posted_q <= '0;
      prev_status_q <= ST_NONE;
      prev_sev_q    <= SEV_NONE;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        last_level_q  <= last_level_d;
        last_posted_q <= last_posted_d;
        prev_status_q <= status;
        prev_sev_q    <= sev;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
